>>> rtl/hotp_pkg.sv
// ----------------------------------------------------------------------------
// hotp_pkg: shared types and constants
// Command and status structs between controller and datapath, HMAC, OTP and key register constants.
// ----------------------------------------------------------------------------
package hotp_pkg;

   localparam int unsigned KEY_BITS = 160;
   localparam logic [7:0] IPAD_BYTE = 8'h36;
   localparam logic [7:0] OPAD_BYTE = 8'h5c;
   localparam logic [31:0] OTP_MODULUS = 32'd1000000;

   localparam logic [1:0] CSR_KEY0 = 2'd0;
   localparam logic [1:0] CSR_KEY1 = 2'd1;
   localparam logic [1:0] CSR_KEY2 = 2'd2;

   // which of the four compression blocks is loaded
   typedef enum logic [1:0] {
      BLK_IPAD  = 2'd0,
      BLK_MSG   = 2'd1,
      BLK_OPAD  = 2'd2,
      BLK_INNER = 2'd3
   } blk_sel_type;

   typedef struct packed {
      logic        load_item;   // latch factor and candidate
      logic        div_step;    // one divider phase
      logic        init_hash;   // load initial chaining value
      logic        load_block;  // load W window and working vars
      blk_sel_type blk_sel;
      logic        round;       // one SHA-1 round
      logic        finish_block; // add working vars into chaining value
      logic        save_inner;  // keep inner digest
      logic        truncate;    // pick dynamic truncation word
      logic        mod_step;    // one subtract step of the reduction
      logic        result;      // compare and load output register
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic round_last;
      logic mod_done;
   } dp_status_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
      rotl = (x << n) | (x >> (32 - n));
   endfunction

endpackage

>>> rtl/hotp_datapath.sv
// ----------------------------------------------------------------------------
// hotp_datapath: factor divider, SHA-1 round unit, truncation and reduction
// One SHA-1 round per cycle with a 16-word schedule window.
// ----------------------------------------------------------------------------
module hotp_datapath #(
   parameter int unsigned TIME_STEP = 30
) (
   input  logic                   clock,
   input  logic                   reset,
   input  hotp_pkg::dp_cmd_type   cmd,
   output hotp_pkg::dp_status_type status,
   input  logic [159:0]           key,
   input  logic                   req_kind,
   input  logic [63:0]            req_moving_value,
   input  logic [19:0]            req_candidate_code,
   output logic [19:0]            code,
   output logic                   match
);
   import hotp_pkg::*;

   // remainder holds values below TIME_STEP, at most 4095
   localparam int unsigned REM_BITS = 12;
   localparam int unsigned DIV_SHIFT = 28 + $clog2(TIME_STEP);
   localparam logic [31:0] DIV_RECIP =
      32'(((64'd1 << DIV_SHIFT) + 64'(TIME_STEP) - 64'd1) / 64'(TIME_STEP));

   logic        kind_ff;
   logic [19:0] cand_ff;
   // divider: 16-bit quotient digits shift into factor, one multiply per digit
   logic [63:0] factor_ff, factor_in;
   logic [REM_BITS-1:0] rem_ff, rem_in;
   logic [27:0] num_ff;
   logic [15:0] quo_ff;
   logic [3:0]  div_cnt_ff;
   logic [6:0]  rnd_ff;
   logic [31:0] w_ff [16];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] h_ff [5];
   logic [159:0] inner_ff;
   logic [31:0] bin_ff;
   logic [4:0]  mod_cnt_ff;
   logic [19:0] code_ff;
   logic        match_ff;

   logic [511:0] blk;
   logic [159:0] kx;
   logic [31:0]  f, k, t, wn;
   logic [159:0] dig;
   logic [3:0]   off;
   logic [27:0]  n_div;
   logic [59:0]  prod;
   logic [31:0]  mod_sub;

   always_comb begin
      kx = key;
      blk = '0;
      unique case (cmd.blk_sel)
         BLK_IPAD:  blk = {kx ^ {20{IPAD_BYTE}}, {44{IPAD_BYTE}}};
         BLK_OPAD:  blk = {kx ^ {20{OPAD_BYTE}}, {44{OPAD_BYTE}}};
         BLK_MSG:   blk = {factor_ff, 8'h80, 376'd0, 64'd576};
         BLK_INNER: blk = {inner_ff, 8'h80, 280'd0, 64'd672};
         default:   blk = '0;
      endcase
   end

   always_comb begin
      priority if (rnd_ff < 7'd20) begin
         f = (b_ff & c_ff) | (~b_ff & d_ff);
         k = 32'h5A827999;
      end else if (rnd_ff < 7'd40) begin
         f = b_ff ^ c_ff ^ d_ff;
         k = 32'h6ED9EBA1;
      end else if (rnd_ff < 7'd60) begin
         f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k = 32'h8F1BBCDC;
      end else begin
         f = b_ff ^ c_ff ^ d_ff;
         k = 32'hCA62C1D6;
      end
      t = rotl(a_ff, 5) + f + e_ff + k + w_ff[0];
      wn = rotl(w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0], 1);
      dig = {h_ff[0], h_ff[1], h_ff[2], h_ff[3], h_ff[4]};
      off = dig[3:0];
      // quotient digit of {remainder, next 16 bits} by reciprocal multiply
      n_div = {rem_ff, factor_ff[63:48]};
      prod = 60'(n_div) * 60'(DIV_RECIP);
      factor_in = {factor_ff[47:0], quo_ff};
      rem_in = REM_BITS'(num_ff - 28'(quo_ff) * 28'(TIME_STEP));
      mod_sub = OTP_MODULUS << (mod_cnt_ff[3:0] - 4'd1);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         kind_ff <= req_kind;
         cand_ff <= req_candidate_code;
         factor_ff <= req_moving_value;
         rem_ff <= '0;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         if (!div_cnt_ff[0]) begin
            num_ff <= n_div;
            quo_ff <= prod[DIV_SHIFT +: 16];
         end else begin
            factor_ff <= factor_in;
            rem_ff <= rem_in;
         end
         div_cnt_ff <= div_cnt_ff + 4'd1;
      end
      if (cmd.init_hash) begin
         h_ff[0] <= 32'h67452301;
         h_ff[1] <= 32'hEFCDAB89;
         h_ff[2] <= 32'h98BADCFE;
         h_ff[3] <= 32'h10325476;
         h_ff[4] <= 32'hC3D2E1F0;
      end
      if (cmd.load_block) begin
         for (int i = 0; i < 16; i++) w_ff[i] <= blk[511-32*i -: 32];
         if (cmd.init_hash) begin
            a_ff <= 32'h67452301; b_ff <= 32'hEFCDAB89; c_ff <= 32'h98BADCFE;
            d_ff <= 32'h10325476; e_ff <= 32'hC3D2E1F0;
         end else begin
            a_ff <= h_ff[0]; b_ff <= h_ff[1]; c_ff <= h_ff[2];
            d_ff <= h_ff[3]; e_ff <= h_ff[4];
         end
         rnd_ff <= '0;
      end else if (cmd.round) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= wn;
         e_ff <= d_ff; d_ff <= c_ff; c_ff <= rotl(b_ff, 30); b_ff <= a_ff; a_ff <= t;
         rnd_ff <= rnd_ff + 7'd1;
      end
      if (cmd.finish_block) begin
         h_ff[0] <= h_ff[0] + a_ff; h_ff[1] <= h_ff[1] + b_ff;
         h_ff[2] <= h_ff[2] + c_ff; h_ff[3] <= h_ff[3] + d_ff;
         h_ff[4] <= h_ff[4] + e_ff;
      end
      if (cmd.save_inner) inner_ff <= dig;
      // twelve steps subtract the modulus shifted by 11 down to 0
      if (cmd.truncate) begin
         bin_ff <= {1'b0, dig[159 - 8*off - 1 -: 31]};
         mod_cnt_ff <= 5'd12;
      end else if (cmd.mod_step) begin
         if (bin_ff >= mod_sub) bin_ff <= bin_ff - mod_sub;
         mod_cnt_ff <= mod_cnt_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff <= '0;
         match_ff <= 1'b0;
      end else if (cmd.result) begin
         code_ff <= bin_ff[19:0];
         match_ff <= (bin_ff[19:0] == cand_ff);
      end
   end

   assign status = '{div_done:   !kind_ff || (div_cnt_ff == 4'd8),
                     round_last: (rnd_ff == 7'd79),
                     mod_done:   (mod_cnt_ff == 5'd0) && !cmd.truncate};
   assign code = code_ff;
   assign match = match_ff;

endmodule

>>> rtl/hotp_ctrl.sv
// ----------------------------------------------------------------------------
// hotp_ctrl: sequencer for one code check
// Divide, four compression blocks, reduce, hand result out; the top adds truncation.
// ----------------------------------------------------------------------------
module hotp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output hotp_pkg::dp_cmd_type    cmd,
   input  hotp_pkg::dp_status_type status
);
   import hotp_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_DIV, S_LOAD, S_ROUND, S_FIN, S_MOD, S_OUT
   } state_type;

   state_type   state_ff;
   blk_sel_type blk_ff;
   logic        rsp_valid_ff;

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      cmd.blk_sel = blk_ff;
      unique case (state_ff)
         S_IDLE:  cmd.load_item = req_valid && req_ready;
         S_DIV:   cmd.div_step = !status.div_done;
         S_LOAD: begin
            cmd.load_block = 1'b1;
            cmd.init_hash = (blk_ff == BLK_IPAD) || (blk_ff == BLK_OPAD);
         end
         S_ROUND: cmd.round = 1'b1;
         S_FIN: begin
            cmd.finish_block = 1'b1;
         end
         S_MOD:   cmd.mod_step = !status.mod_done;
         S_OUT:   cmd.result = 1'b1;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         blk_ff <= BLK_IPAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req_valid && req_ready) begin
               state_ff <= S_DIV;
               blk_ff <= BLK_IPAD;
            end
            S_DIV: if (status.div_done) state_ff <= S_LOAD;
            S_LOAD: state_ff <= S_ROUND;
            S_ROUND: if (status.round_last) state_ff <= S_FIN;
            S_FIN: begin
               // advance to next block; the top level saves the inner digest after the message block
               unique case (blk_ff)
                  BLK_IPAD:  begin blk_ff <= BLK_MSG; state_ff <= S_LOAD; end
                  BLK_MSG:   begin blk_ff <= BLK_OPAD; state_ff <= S_LOAD; end
                  BLK_OPAD:  begin blk_ff <= BLK_INNER; state_ff <= S_LOAD; end
                  BLK_INNER: state_ff <= S_MOD;
                  default:   state_ff <= S_IDLE;
               endcase
            end
            S_MOD: if (status.mod_done) state_ff <= S_OUT;
            S_OUT: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   property p_no_accept_busy;
      @(posedge clock) disable iff (reset) (state_ff != S_IDLE) |-> !req_ready;
   endproperty
   a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

   property p_rsp_hold;
      @(posedge clock) disable iff (reset) (rsp_valid && !rsp_ready) |=> rsp_valid;
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("result dropped");

   property p_out_free;
      @(posedge clock) disable iff (reset) (state_ff == S_OUT) |-> !rsp_valid_ff;
   endproperty
   a_out_free: assert property (p_out_free) else $error("result overwritten");

endmodule

>>> rtl/hmac_sha1_otp_check_top.sv
// ----------------------------------------------------------------------------
// hmac_sha1_otp_check_top: six-digit HOTP/TOTP code checker
// Key registers, controller and datapath.
// ----------------------------------------------------------------------------
// A counter factor goes from acceptance straight to hashing; a time factor is
// first divided by TIME_STEP (four 16-bit quotient digits, each a reciprocal
// multiply step and a remainder step). Four SHA-1 blocks follow, each a load,
// the rounds and an add, through a single round unit, then one truncation, 12
// reduction steps and the output register. The next item is taken once the
// result is accepted.
module hmac_sha1_otp_check_top #(
   parameter int unsigned TIME_STEP = 30
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [63:0] req_moving_value,
   input  logic [19:0] req_candidate_code,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [19:0] rsp_computed_code,
   output logic        rsp_code_valid,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);
   import hotp_pkg::*;

   logic [63:0] key0_ff, key1_ff;
   logic [31:0] key2_ff;
   dp_cmd_type    cmd;
   dp_status_type status;
   logic save_pulse_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff <= '0; key1_ff <= '0; key2_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_KEY0: key0_ff <= csr_data;
            CSR_KEY1: key1_ff <= csr_data;
            CSR_KEY2: key2_ff <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   // keep inner digest right after the message block's add
   dp_cmd_type cmd_dp;
   always_comb begin
      cmd_dp = cmd;
      cmd_dp.save_inner = save_pulse_ff;
      cmd_dp.truncate = save_pulse_ff ? 1'b0 : cmd.truncate;
   end

   logic fin_msg_ff, fin_last_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         save_pulse_ff <= 1'b0; fin_msg_ff <= 1'b0; fin_last_ff <= 1'b0;
      end else begin
         save_pulse_ff <= cmd.finish_block && (cmd.blk_sel == BLK_MSG);
         fin_last_ff <= cmd.finish_block && (cmd.blk_sel == BLK_INNER);
         fin_msg_ff <= fin_last_ff;
      end
   end

   dp_cmd_type cmd_fix;
   always_comb begin
      cmd_fix = cmd_dp;
      cmd_fix.truncate = fin_last_ff;
      cmd_fix.mod_step = cmd_dp.mod_step && !fin_last_ff;
   end

   hotp_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .cmd, .status
   );

   hotp_datapath #(.TIME_STEP(TIME_STEP)) u_dp (
      .clock, .reset, .cmd(cmd_fix), .status,
      .key({key0_ff, key1_ff, key2_ff}),
      .req_kind, .req_moving_value, .req_candidate_code,
      .code(rsp_computed_code), .match(rsp_code_valid)
   );

   property p_trunc_order;
      @(posedge clock) disable iff (reset) fin_last_ff |-> !save_pulse_ff;
   endproperty
   a_trunc_order: assert property (p_trunc_order) else $error("truncate overlap");

   property p_last_follow;
      @(posedge clock) disable iff (reset) fin_last_ff |=> fin_msg_ff;
   endproperty
   a_last_follow: assert property (p_last_follow) else $error("pipeline slip");

   property p_busy_hold;
      @(posedge clock) disable iff (reset) save_pulse_ff |-> !req_ready;
   endproperty
   a_busy_hold: assert property (p_busy_hold) else $error("accept mid hash");

endmodule

>>> tb/sv/hotp_checker.sv
// ----------------------------------------------------------------------------
// hotp_checker: HOTP/TOTP code predictor and result scoreboard
// Watches the request, response and key-write channels, computes HMAC-SHA1
// codes for each accepted request and compares them with the responses.
// ----------------------------------------------------------------------------
module hotp_checker #(
   parameter int unsigned TIME_STEP = 30
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_kind,
   input  logic [63:0] req_moving_value,
   input  logic [19:0] req_candidate_code,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [19:0] rsp_computed_code,
   input  logic        rsp_code_valid,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data,
   output int          fail_count,
   output int          pending_count
);
   import hotp_pkg::*;

   typedef struct packed {
      logic [19:0] code;
      logic        match;
   } otp_result_type;

   logic [159:0]   key_q;
   otp_result_type code_queue[$];

   function automatic logic [31:0] rol32(logic [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic void compress(inout logic [31:0] h[5], input logic [511:0] blk);
      logic [31:0] w[80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
      for (int i = 16; i < 80; i++) w[i] = rol32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d); k = 32'h5A827999;
         end else if (i < 40) begin
            f = b ^ c ^ d; k = 32'h6ED9EBA1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
         end else begin
            f = b ^ c ^ d; k = 32'hCA62C1D6;
         end
         t = rol32(a, 5) + f + e + k + w[i];
         e = d; d = c; c = rol32(b, 30); b = a; a = t;
      end
      h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
   endfunction

   // pad block then one tail block of tail_len bytes, message left-aligned in tail
   function automatic logic [159:0] digest_pad_tail(logic [511:0] pad, logic [511:0] tail,
                                                    int tail_len);
      logic [31:0]  h[5];
      logic [511:0] blk;
      h[0] = 32'h67452301; h[1] = 32'hEFCDAB89; h[2] = 32'h98BADCFE;
      h[3] = 32'h10325476; h[4] = 32'hC3D2E1F0;
      compress(h, pad);
      blk = tail;
      blk[511 - 8 * tail_len -: 8] = 8'h80;
      blk[63:0] = 64'(64 + tail_len) * 8;
      compress(h, blk);
      return {h[0], h[1], h[2], h[3], h[4]};
   endfunction

   function automatic otp_result_type predict_code(logic kind, logic [63:0] mv,
                                                   logic [19:0] cand);
      logic [511:0]   ipad, opad, tail;
      logic [159:0]   inner, mac;
      logic [63:0]    factor;
      logic [31:0]    bin;
      int             off;
      otp_result_type r;
      ipad = {64{IPAD_BYTE}};
      opad = {64{OPAD_BYTE}};
      ipad[511 -: 160] ^= key_q;
      opad[511 -: 160] ^= key_q;
      factor = kind ? mv / 64'(TIME_STEP) : mv;
      tail = '0;
      tail[511 -: 64] = factor;
      inner = digest_pad_tail(ipad, tail, 8);
      tail = '0;
      tail[511 -: 160] = inner;
      mac = digest_pad_tail(opad, tail, 20);
      off = int'(mac[3:0]);
      bin = mac[159 - 8 * off -: 32];
      bin[31] = 1'b0;
      r.code = 20'(bin % OTP_MODULUS);
      r.match = (r.code == cand);
      return r;
   endfunction

   always @(posedge clock) begin
      otp_result_type exp_r;
      int errs;
      errs = 0;
      if (reset) begin
         key_q <= '0;
         fail_count <= 0;
         pending_count <= 0;
         code_queue.delete();
      end else begin
         if (req_valid && req_ready)
            code_queue.push_back(predict_code(req_kind, req_moving_value, req_candidate_code));
         if (rsp_valid && rsp_ready) begin
            if (code_queue.size() == 0) begin
               $error("unexpected item: computed_code %0d", rsp_computed_code);
               errs++;
            end else begin
               exp_r = code_queue.pop_front();
               if (rsp_computed_code !== exp_r.code) begin
                  $error("computed_code expected %0d actual %0d", exp_r.code,
                         rsp_computed_code);
                  errs++;
               end
               if (rsp_code_valid !== exp_r.match) begin
                  $error("code_valid expected %0d actual %0d", exp_r.match, rsp_code_valid);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
         pending_count <= code_queue.size();
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_KEY0: key_q[159:96] <= csr_data;
               CSR_KEY1: key_q[95:32] <= csr_data;
               CSR_KEY2: key_q[31:0] <= csr_data[31:0];
               default: ;
            endcase
         end
      end
   end
endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the HOTP/TOTP checker
// Loads several keys, sends directed and random requests with random idling
// on both channels, and reports a verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module testbench;
   import hotp_pkg::*;

   localparam int unsigned TIME_STEP = 30;
   localparam int LIMIT = 2000000;
   localparam logic [1:0] CSR_NONE = 2'd3;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic        req_kind = 0;
   logic [63:0] req_moving_value = '0;
   logic [19:0] req_candidate_code = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [19:0] rsp_computed_code;
   logic        rsp_code_valid;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_data = '0;
   int          fail_count;
   int          pending_count;
   int          cycle_count = 0;
   int          send_idle_pct = 8;
   int          recv_idle_pct = 63;

   hmac_sha1_otp_check_top #(.TIME_STEP(TIME_STEP)) u_dut (.*);

   hotp_checker #(.TIME_STEP(TIME_STEP)) u_checker (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // valid stays up into the next item unless the sender idles
   task automatic send_code(logic kind, logic [63:0] mv, logic [19:0] cand);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_kind <= kind;
      req_moving_value <= mv;
      req_candidate_code <= cand;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_key(logic [1:0] idx, logic [63:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic drain();
      req_valid <= 0;
      do @(posedge clock); while (pending_count != 0);
      repeat (50) @(posedge clock);
   endtask

   task automatic load_key(logic [159:0] k);
      write_key(CSR_KEY0, k[159:96]);
      write_key(CSR_KEY1, k[95:32]);
      // upper half of the short register must be ignored
      write_key(CSR_KEY2, {$urandom(), k[31:0]});
      // index past the list: dropped
      write_key(CSR_NONE, {$urandom(), $urandom()});
      csr_valid <= 0;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic random_phase(int n);
      logic [63:0] mv;
      logic [19:0] cand;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(3))
            0: mv = rand64();
            1: mv = 64'($urandom_range(1000));
            2: mv = ~64'($urandom_range(1000));
            default: mv = 64'($urandom());
         endcase
         cand = ($urandom_range(9) == 0) ? 20'($urandom_range(1048575, 999990))
                                         : 20'($urandom_range(999999));
         send_code(1'($urandom_range(1)), mv, cand);
      end
   endtask

   initial begin
      logic [159:0] rfc_key;
      rfc_key = "12345678901234567890";
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset key is all zeros
      send_code(0, 64'd0, 20'd0);
      send_code(1, 64'hFFFF_FFFF_FFFF_FFFF, 20'hFFFFF);
      drain();

      load_key(rfc_key);
      // HOTP counter 0 gives 755224, counter 1 gives 287082
      send_code(0, 64'd0, 20'd755224);
      send_code(0, 64'd1, 20'd287082);
      send_code(0, 64'd9, 20'd520489);
      send_code(1, 64'd59, 20'd287082);
      send_code(1, 64'd29, 20'd0);
      send_code(1, 64'd30, 20'd999999);
      send_code(0, 64'hFFFF_FFFF_FFFF_FFFF, 20'd1000000);
      send_code(1, 64'd20000000000, 20'hFFFFF);
      send_code(0, 64'h8000_0000_0000_0000, 20'd999999);
      send_code(1, 64'h0000_0000_FFFF_FFFF, 20'd0);
      drain();

      load_key({160{1'b1}});
      send_code(0, 64'd0, 20'd0);
      send_code(1, 64'hFFFF_FFFF_FFFF_FFFF, 20'd999999);
      drain();

      load_key({rand64(), rand64(), $urandom()});
      random_phase(170);
      drain();
      send_idle_pct = 63;
      recv_idle_pct = 8;
      load_key({rand64(), 96'd0});
      random_phase(170);
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_key({rand64(), rand64(), $urandom()});
      random_phase(160);
      drain();

      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
